// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the compensation block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define PTC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that must also hold while reset is asserted.
`define PTC_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ptc_pkg.sv =====
// Package for the pressure and temperature compensation block.
// Holds register indexes, fixed constants, the truncating shift helper and a magnitude helper.
`default_nettype none

package ptc_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_CAL_A = 2'd0;
	localparam logic [1:0] REG_CAL_B = 2'd1;
	localparam logic [1:0] REG_CAL_C = 2'd2;

	localparam int unsigned DIV_W = 32;

	localparam logic signed [31:0] B6_OFFSET = 32'sd4000;
	localparam logic signed [31:0] K_3038    = 32'sd3038;
	localparam logic signed [31:0] K_M7357   = -32'sd7357;
	localparam logic signed [31:0] K_3791    = 32'sd3791;
	localparam logic [31:0]        K_50000   = 32'd50000;
	localparam logic [31:0]        K_32768   = 32'd32768;

	// Signed division by 2**k, rounding toward zero.
	function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] a,
			input int unsigned k);
		logic signed [31:0] bias;
		bias = a[31] ? signed'((32'd1 << k) - 32'd1) : 32'sd0;
		return (a + bias) >>> k;
	endfunction

	// Magnitude of a signed word as an unsigned word.
	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		return a[31] ? (32'd0 - unsigned'(a)) : unsigned'(a);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ptc_udiv.sv =====
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// Uses ptc_pkg for the number of stages.
`default_nettype none

module ptc_udiv (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic      [31:0] quotient
);

	localparam int unsigned N = ptc_pkg::DIV_W;

	// num_q shifts the dividend out at the top and the quotient in at the bottom.
	logic [31:0] rem_q [N];
	logic [31:0] num_q [N];
	logic [31:0] den_q [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [31:0] rem_in, num_in, den_in;
		logic [32:0] cand;
		logic        take;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = dividend;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign num_in = num_q[i-1];
			assign den_in = den_q[i-1];
		end

		assign cand = {rem_in, num_in[31]};
		assign take = (cand >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= take ? 32'(cand - {1'b0, den_in}) : cand[31:0];
				num_q[i] <= {num_in[30:0], take};
				den_q[i] <= den_in;
			end
		end
	end

	assign quotient = num_q[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/pressure_temperature_compensation_unit.sv =====
// Compensation of raw barometric sensor readings (oversampling setting 0).
// Depends on ptc_pkg, ptc_udiv and assert_macros.svh.
//
// Use: a request on the input channel carries one raw temperature and one
// raw pressure reading, and is taken when in_valid and in_ready are both
// high. Each request yields exactly one result on the output channel:
// temperature in tenths of a degree, pressure in pascals and a flag that
// is set (with both values forced to zero) when a divisor came out zero.
// The calibration coefficients live in three registers written over the
// cfg_we / cfg_index / cfg_data port; write them only while no request is
// in flight. Writes to an unused index are ignored.
//
// The pipeline has fifteen arithmetic stages plus two 32-stage restoring
// dividers, one for the temperature term and one for the pressure quotient.
// A new request can be taken in every cycle while the receiver accepts
// results, so throughput is one result per cycle.
//
// Reset clears all valid bits and the calibration registers. When the
// receiver holds out_ready low while a result is shown, the whole pipeline
// freezes in place and in_ready drops; nothing is lost or repeated.
`default_nettype none

module pressure_temperature_compensation_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        raw_temp,
	input  wire logic [15:0]        raw_press,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      temp_tenths,
	output logic signed [31:0]      press_pa,
	output logic                    div_error
);

	`include "assert_macros.svh"

	localparam int unsigned N = ptc_pkg::DIV_W;

	// Calibration registers.
	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptc_pkg::REG_CAL_A: cal_a_q <= cfg_data;
				ptc_pkg::REG_CAL_B: cal_b_q <= cfg_data;
				ptc_pkg::REG_CAL_C: cal_c_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Coefficients widened to 32 bits; signed ones are sign extended.
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0]        ac4, ac5, ac6;
	logic signed [31:0] mc_num, ac1_x4;

	assign ac1 = 32'(signed'(cal_a_q[15:0]));
	assign ac2 = 32'(signed'(cal_a_q[31:16]));
	assign ac3 = 32'(signed'(cal_a_q[47:32]));
	assign ac4 = {16'h0, cal_a_q[63:48]};
	assign ac5 = {16'h0, cal_b_q[15:0]};
	assign ac6 = {16'h0, cal_b_q[31:16]};
	assign b1  = 32'(signed'(cal_b_q[47:32]));
	assign b2  = 32'(signed'(cal_b_q[63:48]));
	assign mc  = 32'(signed'(cal_c_q[15:0]));
	assign md  = 32'(signed'(cal_c_q[31:16]));
	assign mc_num = mc <<< 11;
	assign ac1_x4 = ac1 <<< 2;

	// The whole pipeline moves together unless a shown result is refused.
	logic adv;
	assign adv      = !(out_valid && !out_ready);
	assign in_ready = adv;

	// Valid bits of the arithmetic stages.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15;

	// Side information that travels alongside the two dividers.
	typedef struct packed {
		logic signed [31:0] x1;
		logic [15:0]        up;
		logic               dz;
		logic               neg;
	} side1_t;

	typedef struct packed {
		logic signed [31:0] temp;
		logic               err;
		logic               sh;
	} side2_t;

	side1_t side1_q [N];
	side2_t side2_q [N];
	logic   side1_vld_q [N];
	logic   side2_vld_q [N];

	// Stage registers.
	logic signed [31:0] mul1_s1, x1_s2, den_s2, x1_s3;
	logic [15:0]        up_s1, up_s2, up_s3, up_s4, up_s5, up_s6, up_s7, up_s8, up_s9;
	logic [31:0]        ua_s3, ub_s3;
	logic               dz_s3, neg_s3;
	logic signed [31:0] b5_s4, temp_s5, b6_s5;
	logic signed [31:0] sq_s6, ma2_s6, ma3_s6, temp_s6;
	logic signed [31:0] b6sq_s7, xa2_s7, xc1_s7, temp_s7;
	logic signed [31:0] mb2_s8, mb1_s8, xa2_s8, xc1_s8, temp_s8;
	logic signed [31:0] b3_s9, x3_s9, temp_s9;
	logic [31:0]        m4_s10, b7_s10;
	logic signed [31:0] temp_s10, temp_s11;
	logic               dz_s4, dz_s5, dz_s6, dz_s7, dz_s8, dz_s9, dz_s10, err_s11;
	logic [31:0]        b4_s11, dvd_s11;
	logic               sh_s11;
	logic signed [31:0] p_s12, r_s12, m7_s12, temp_s12;
	logic signed [31:0] p_s13, rr_s13, x2_s13, temp_s13;
	logic signed [31:0] p_s14, m3_s14, x2_s14, temp_s14;
	logic               err_s12, err_s13, err_s14;
	logic signed [31:0] temp_s15, press_s15;
	logic               err_s15;

	logic [31:0] q1, q2;

	ptc_udiv u_div_temp (
		.clk      (clk),
		.en       (adv),
		.dividend (ua_s3),
		.divisor  (ub_s3),
		.quotient (q1)
	);

	ptc_udiv u_div_press (
		.clk      (clk),
		.en       (adv),
		.dividend (dvd_s11),
		.divisor  (b4_s11),
		.quotient (q2)
	);

	// Valid bits, reset to empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			{v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15} <= '0;
			for (int i = 0; i < N; i++) begin
				side1_vld_q[i] <= 1'b0;
				side2_vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			side1_vld_q[0] <= v_s3;
			side2_vld_q[0] <= v_s11;
			for (int i = 1; i < N; i++) begin
				side1_vld_q[i] <= side1_vld_q[i-1];
				side2_vld_q[i] <= side2_vld_q[i-1];
			end
			v_s4  <= side1_vld_q[N-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= side2_vld_q[N-1];
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	// Payload of the pipeline; no reset needed.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Temperature: x1 term and the divider operands.
			mul1_s1 <= signed'(32'(({16'h0, raw_temp} - ac6) * ac5));
			up_s1   <= raw_press;

			x1_s2   <= ptc_pkg::sdiv_pow2(mul1_s1, 15);
			den_s2  <= ptc_pkg::sdiv_pow2(mul1_s1, 15) + md;
			up_s2   <= up_s1;

			x1_s3   <= x1_s2;
			up_s3   <= up_s2;
			dz_s3   <= (den_s2 == 32'sd0);
			neg_s3  <= mc_num[31] ^ den_s2[31];
			ua_s3   <= ptc_pkg::mag32(mc_num);
			ub_s3   <= ptc_pkg::mag32(den_s2);

			side1_q[0].x1  <= x1_s3;
			side1_q[0].up  <= up_s3;
			side1_q[0].dz  <= dz_s3;
			side1_q[0].neg <= neg_s3;
			for (int i = 1; i < N; i++) begin
				side1_q[i].x1  <= side1_q[i-1].x1;
				side1_q[i].up  <= side1_q[i-1].up;
				side1_q[i].dz  <= side1_q[i-1].dz;
				side1_q[i].neg <= side1_q[i-1].neg;
			end

			// b5, temperature and b6.
			b5_s4   <= side1_q[N-1].x1 +
				(side1_q[N-1].neg ? signed'(32'd0 - q1) : signed'(q1));
			up_s4   <= side1_q[N-1].up;
			dz_s4   <= side1_q[N-1].dz;

			temp_s5 <= ptc_pkg::sdiv_pow2(b5_s4 + 32'sd8, 4);
			b6_s5   <= b5_s4 - ptc_pkg::B6_OFFSET;
			up_s5   <= up_s4;
			dz_s5   <= dz_s4;

			// Products of b6.
			sq_s6   <= b6_s5 * b6_s5;
			ma2_s6  <= ac2 * b6_s5;
			ma3_s6  <= ac3 * b6_s5;
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			dz_s6   <= dz_s5;

			b6sq_s7 <= ptc_pkg::sdiv_pow2(sq_s6, 12);
			xa2_s7  <= ptc_pkg::sdiv_pow2(ma2_s6, 11);
			xc1_s7  <= ptc_pkg::sdiv_pow2(ma3_s6, 13);
			temp_s7 <= temp_s6;
			up_s7   <= up_s6;
			dz_s7   <= dz_s6;

			mb2_s8  <= b2 * b6sq_s7;
			mb1_s8  <= b1 * b6sq_s7;
			xa2_s8  <= xa2_s7;
			xc1_s8  <= xc1_s7;
			temp_s8 <= temp_s7;
			up_s8   <= up_s7;
			dz_s8   <= dz_s7;

			// b3 and the x3 term feeding b4.
			b3_s9   <= ptc_pkg::sdiv_pow2(ac1_x4 +
				(ptc_pkg::sdiv_pow2(mb2_s8, 11) + xa2_s8) + 32'sd2, 2);
			x3_s9   <= ptc_pkg::sdiv_pow2(xc1_s8 +
				ptc_pkg::sdiv_pow2(mb1_s8, 16) + 32'sd2, 2);
			temp_s9 <= temp_s8;
			up_s9   <= up_s8;
			dz_s9   <= dz_s8;

			// Unsigned stage: b4 product and b7.
			m4_s10   <= 32'(ac4 * (unsigned'(x3_s9) + ptc_pkg::K_32768));
			b7_s10   <= 32'(({16'h0, up_s9} - unsigned'(b3_s9)) * ptc_pkg::K_50000);
			temp_s10 <= temp_s9;
			dz_s10   <= dz_s9;

			// When b7 has its top bit set, the doubling moves after the divide.
			b4_s11   <= m4_s10 >> 15;
			err_s11  <= dz_s10 || ((m4_s10 >> 15) == 32'd0);
			sh_s11   <= b7_s10[31];
			dvd_s11  <= b7_s10[31] ? b7_s10 : (b7_s10 << 1);
			temp_s11 <= temp_s10;

			side2_q[0].temp <= temp_s11;
			side2_q[0].err  <= err_s11;
			side2_q[0].sh   <= sh_s11;
			for (int i = 1; i < N; i++) begin
				side2_q[i].temp <= side2_q[i-1].temp;
				side2_q[i].err  <= side2_q[i-1].err;
				side2_q[i].sh   <= side2_q[i-1].sh;
			end

			// Final pressure correction.
			p_s12    <= signed'(side2_q[N-1].sh ? (q2 << 1) : q2);
			r_s12    <= ptc_pkg::sdiv_pow2(
				signed'(side2_q[N-1].sh ? (q2 << 1) : q2), 8);
			m7_s12   <= ptc_pkg::K_M7357 *
				signed'(side2_q[N-1].sh ? (q2 << 1) : q2);
			temp_s12 <= side2_q[N-1].temp;
			err_s12  <= side2_q[N-1].err;

			p_s13    <= p_s12;
			rr_s13   <= r_s12 * r_s12;
			x2_s13   <= ptc_pkg::sdiv_pow2(m7_s12, 16);
			temp_s13 <= temp_s12;
			err_s13  <= err_s12;

			p_s14    <= p_s13;
			m3_s14   <= rr_s13 * ptc_pkg::K_3038;
			x2_s14   <= x2_s13;
			temp_s14 <= temp_s13;
			err_s14  <= err_s13;

			// Output register; a zero divisor forces both values to zero.
			temp_s15  <= err_s14 ? 32'sd0 : temp_s14;
			press_s15 <= err_s14 ? 32'sd0 : p_s14 + ptc_pkg::sdiv_pow2(
				ptc_pkg::sdiv_pow2(m3_s14, 16) + x2_s14 + ptc_pkg::K_3791, 4);
			err_s15   <= err_s14;
		end
	end

	assign out_valid   = v_s15;
	assign temp_tenths = temp_s15;
	assign press_pa    = press_s15;
	assign div_error   = err_s15;

	`PTC_ASSERT(a_err_zero, clk, arst_n, out_valid && div_error |-> temp_tenths == 32'sd0 && press_pa == 32'sd0, "error result with nonzero values")
	`PTC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid, "result shown during reset")
	`PTC_ASSERT(a_freeze, clk, arst_n, !adv |=> $stable(b5_s4) && $stable(v_s4) && $stable(p_s12), "pipeline moved while stalled")
	`PTC_ASSERT(a_b4_zero, clk, arst_n, adv && v_s10 && (m4_s10 >> 15) == 32'd0 |=> err_s11, "zero b4 not flagged")

endmodule

`default_nettype wire

// ===== tb/sv/ptc_checker.sv =====
// Checker for the pressure and temperature compensation unit.
// Watches both channels, computes the expected compensated readings and compares them.
// Depends on ptc_pkg for the register indexes.
`timescale 1ns / 1ps

module ptc_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [15:0]        raw_temp,
	input  wire logic [15:0]        raw_press,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [31:0] temp_tenths,
	input  wire logic signed [31:0] press_pa,
	input  wire logic               div_error,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic signed [31:0] temp;
		logic signed [31:0] press;
		logic               err;
	} reading_t;

	logic [63:0] cal_a, cal_b;
	logic [31:0] cal_c;
	reading_t    expected_readings[$];

	// Truncating signed division; the divisor is never zero here.
	function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [31:0] ua, ub, q;
		ua = a[31] ? 32'd0 - a : a;
		ub = b[31] ? 32'd0 - b : b;
		q  = ua / ub;
		return (a[31] != b[31]) ? 32'd0 - q : q;
	endfunction

	function automatic reading_t compensate(input logic [15:0] ut, input logic [15:0] up);
		logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		logic signed [31:0] x1, x2, x3, den, b5, b6, b6sq, b3, p;
		logic [31:0] ac4, b4, b7, pu;
		reading_t r;
		ac1 = signed'(cal_a[15:0]);
		ac2 = signed'(cal_a[31:16]);
		ac3 = signed'(cal_a[47:32]);
		ac4 = {16'd0, cal_a[63:48]};
		ac5 = {16'd0, cal_b[15:0]};
		ac6 = {16'd0, cal_b[31:16]};
		b1  = signed'(cal_b[47:32]);
		b2  = signed'(cal_b[63:48]);
		mc  = signed'(cal_c[15:0]);
		md  = signed'(cal_c[31:16]);
		r = '{temp: 0, press: 0, err: 1'b1};
		x1  = tdiv(({16'd0, ut} - ac6) * ac5, 32768);
		den = x1 + md;
		if (den == 0)
			return r;
		x2 = tdiv(mc * 2048, den);
		b5 = x1 + x2;
		r.temp = tdiv(b5 + 8, 16);
		b6   = b5 - 4000;
		b6sq = tdiv(b6 * b6, 4096);
		x3 = tdiv(b2 * b6sq, 2048) + tdiv(ac2 * b6, 2048);
		b3 = tdiv(ac1 * 4 + x3 + 2, 4);
		x3 = tdiv(tdiv(ac3 * b6, 8192) + tdiv(b1 * b6sq, 65536) + 2, 4);
		b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
		if (b4 == 0) begin
			r.temp = 0;
			return r;
		end
		b7 = ({16'd0, up} - b3) * 32'd50000;
		pu = (b7 < 32'h8000_0000) ? (b7 * 2) / b4 : (b7 / b4) * 2;
		p  = pu;
		x1 = tdiv(tdiv(p, 256) * tdiv(p, 256) * 3038, 65536);
		x2 = tdiv(-32'sd7357 * p, 65536);
		r.press = p + tdiv(x1 + x2 + 3791, 16);
		r.err = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			cal_a = 0;
			cal_b = 0;
			cal_c = 0;
			fail_count = 0;
			expected_readings.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result temp %0d press %0d err %0b",
						$time, temp_tenths, press_pa, div_error);
					fail_count++;
				end else begin
					e = expected_readings.pop_front();
					if (e.temp !== temp_tenths || e.press !== press_pa
							|| e.err !== div_error) begin
						$display("%0t: expected temp %0d press %0d err %0b, got %0d %0d %0b",
							$time, e.temp, e.press, e.err, temp_tenths, press_pa,
							div_error);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_readings.push_back(compensate(raw_temp, raw_press));
			if (cfg_we) begin
				case (cfg_index)
					ptc_pkg::REG_CAL_A: cal_a = cfg_data;
					ptc_pkg::REG_CAL_B: cal_b = cfg_data;
					ptc_pkg::REG_CAL_C: cal_c = cfg_data[31:0];
					default: ;
				endcase
			end
			pending = expected_readings.size();
		end
	end
endmodule

// ===== tb/sv/tb_pressure_temperature_compensation_unit.sv =====
// Top level of the testbench for the pressure and temperature compensation unit.
// Drives requests and calibration writes; ptc_checker does all the checking.
// Depends on ptc_pkg, ptc_checker and the unit itself.
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation_unit;

	// Depth of the unit's pipeline, from accepting a request to showing its result.
	localparam int LATENCY = 79;

	// An index that names no register; writes to it are ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = ptc_pkg::REG_CAL_A;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] raw_temp = '0;
	logic [15:0] raw_press = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] temp_tenths, press_pa;
	logic div_error;
	int fail_count, pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	always #5 clk = ~clk;

	pressure_temperature_compensation_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.raw_temp(raw_temp), .raw_press(raw_press), .out_valid(out_valid),
		.out_ready(out_ready), .temp_tenths(temp_tenths), .press_pa(press_pa),
		.div_error(div_error)
	);

	ptc_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.raw_temp(raw_temp), .raw_press(raw_press), .out_valid(out_valid),
		.out_ready(out_ready), .temp_tenths(temp_tenths), .press_pa(press_pa),
		.div_error(div_error), .fail_count(fail_count), .pending(pending)
	);

	// The receiver stalls at random, or holds off completely while a long
	// hold-off is counting down in this process.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one request and waits for it to be taken. Idle cycles come
	// before valid is raised, so valid never drops while a request waits.
	task automatic send_request(input logic [15:0] ut, input logic [15:0] up);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		raw_temp  <= ut;
		raw_press <= up;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Lowers valid and waits until every expected result has come back,
	// plus the pipeline depth for safety.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Realistic calibration, perturbed by random offsets so results vary.
	task automatic write_typical_cal;
		logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		ac1 = 16'd408 + 16'($urandom_range(8000));
		ac2 = -16'sd72 - 16'($urandom_range(1000));
		ac3 = -16'sd14383 + 16'($urandom_range(2000));
		ac4 = 16'd32741 + 16'($urandom_range(2000));
		ac5 = 16'd32757 - 16'($urandom_range(10000));
		ac6 = 16'd23153 + 16'($urandom_range(2000));
		b1  = 16'd6190 + 16'($urandom_range(500));
		b2  = 16'd4 + 16'($urandom_range(100));
		mc  = -16'sd8711 + 16'($urandom_range(1000));
		md  = 16'd2868 + 16'($urandom_range(500));
		write_reg(ptc_pkg::REG_CAL_A, {ac4, ac3, ac2, ac1});
		write_reg(ptc_pkg::REG_CAL_B, {b2, b1, ac6, ac5});
		write_reg(ptc_pkg::REG_CAL_C, {32'd0, md, mc});
	endtask

	task automatic random_phase(input int count, input int idle, input int stall);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (count) begin
			if ($urandom_range(3) == 0)
				send_request(16'($urandom), 16'($urandom));
			else
				send_request(16'd27898 + 16'($urandom_range(6000)) - 16'd3000,
					16'd23843 + 16'($urandom_range(10000)) - 16'd5000);
		end
		drain();
	endtask

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the textbook readings and calibration with ac6 changed, then field extremes.
		write_reg(ptc_pkg::REG_CAL_A, {16'd32741, -16'sd14383, -16'sd72, 16'sd408});
		write_reg(ptc_pkg::REG_CAL_B, {16'sd4, 16'sd6190, 16'd4743, 16'd32757});
		write_reg(ptc_pkg::REG_CAL_C, {32'd0, 16'sd2868, -16'sd8711});
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(16'd27898, 16'd23843);
		send_request(16'h0000, 16'h0000);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h0000, 16'hFFFF);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'h5555, 16'hAAAA);
		send_request(16'hAAAA, 16'h5555);
		drain();

		// All-zero calibration: x1 + md is zero, so the temperature divisor fails.
		write_reg(ptc_pkg::REG_CAL_A, 64'd0);
		write_reg(ptc_pkg::REG_CAL_B, 64'd0);
		write_reg(ptc_pkg::REG_CAL_C, 64'd0);
		send_request(16'd1234, 16'd4321);
		send_request(16'hFFFF, 16'hFFFF);
		drain();

		// Temperature passes but ac4 is zero, so b4 is zero.
		write_reg(ptc_pkg::REG_CAL_C, {32'd0, 16'sd100, 16'sd0});
		send_request(16'd500, 16'd500);
		drain();

		// Every calibration bit set, then a mixed extreme pattern.
		write_reg(ptc_pkg::REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(ptc_pkg::REG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(ptc_pkg::REG_CAL_C, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(16'h0000, 16'h0000);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h8000, 16'h7FFF);
		drain();
		write_reg(ptc_pkg::REG_CAL_A, 64'h8000_7FFF_8000_7FFF);
		write_reg(ptc_pkg::REG_CAL_B, 64'h7FFF_8000_FFFF_0001);
		write_reg(ptc_pkg::REG_CAL_C, {32'd0, 16'h7FFF, 16'h8000});
		send_request(16'h0000, 16'hFFFF);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'h7FFF, 16'h8000);
		drain();

		// Random phases with realistic calibration and varied flow control.
		write_typical_cal();
		random_phase(150, 0, 0);
		write_typical_cal();
		random_phase(150, 48, 0);

		// Wholly random calibration words.
		write_reg(ptc_pkg::REG_CAL_A, {$urandom, $urandom});
		write_reg(ptc_pkg::REG_CAL_B, {$urandom, $urandom});
		write_reg(ptc_pkg::REG_CAL_C, {$urandom, $urandom});
		random_phase(150, 0, 48);

		// Long receiver hold-off while the sender keeps offering requests,
		// so the pipeline fills and in_ready drops.
		write_typical_cal();
		hold_cycles = 300;
		random_phase(150, 0, 0);

		write_typical_cal();
		random_phase(100, 35, 35);
		write_reg(ptc_pkg::REG_CAL_A, {$urandom, $urandom});
		write_reg(ptc_pkg::REG_CAL_B, {$urandom, $urandom});
		write_reg(ptc_pkg::REG_CAL_C, {$urandom, $urandom});
		random_phase(120, 35, 35);

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
